### sv/lshl_pkg.sv
// ----------------------------------------------------------------------------
// lshl_pkg
// Shared sizes, codes and structs of the layer-sorted handle list.
// ----------------------------------------------------------------------------
package lshl_pkg;

  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 16;
  localparam int LAYER_BITS  = 16;

  // Port field widths (fixed)
  localparam int CMD_W    = 2;
  localparam int FHND_W   = 16;
  localparam int FLAY_W   = 16;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 2;
  localparam int FIDX_W   = 4;
  localparam int FCNT_W   = 5;

  // Internal widths
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0]        handle;
    logic signed [LAYER_BITS-1:0]  layer;
  } slot_t;

  // Command broadcast to every cell
  typedef struct packed {
    cmd_t                          cmd;
    logic [HANDLE_BITS-1:0]        handle;
    logic signed [LAYER_BITS-1:0]  layer;
    logic [POS_W-1:0]              pos;
    logic [CNT_W-1:0]              count;
    logic                          wr_en;
  } op_t;

  // Hit carried down the chain, at most one cell sets it
  typedef struct packed {
    logic                          found;
    logic [HANDLE_BITS-1:0]        handle;
    logic signed [LAYER_BITS-1:0]  layer;
    logic [IDX_W-1:0]              idx;
  } hit_t;

endpackage

### sv/lshl_req_if.sv
// ----------------------------------------------------------------------------
// lshl_req_if
// Command channel: valid/ready plus the command fields.
// ----------------------------------------------------------------------------
interface lshl_req_if
  import lshl_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [FHND_W-1:0]         handle;
  logic signed [FLAY_W-1:0]  layer;
  logic [POS_W-1:0]          position;

  modport source (output valid, cmd, handle, layer, position, input ready);
  modport sink   (input valid, cmd, handle, layer, position, output ready);
endinterface

### sv/lshl_rsp_if.sv
// ----------------------------------------------------------------------------
// lshl_rsp_if
// Result channel: valid/ready plus the result fields.
// ----------------------------------------------------------------------------
interface lshl_rsp_if
  import lshl_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic [FHND_W-1:0]         handle_out;
  logic signed [FLAY_W-1:0]  layer_out;
  logic [FIDX_W-1:0]         index_out;
  logic [FCNT_W-1:0]         count;

  modport source (output valid, status, handle_out, layer_out, index_out, count,
                  input ready);
  modport sink   (input valid, status, handle_out, layer_out, index_out, count,
                  output ready);
endinterface

### sv/lshl_cell.sv
// ----------------------------------------------------------------------------
// lshl_cell
// One slot of the list: compares against the command, shifts with neighbors.
// ----------------------------------------------------------------------------
module lshl_cell
  import lshl_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  op_t              op,
  input  slot_t            prev,
  input  logic             prev_gt,
  input  slot_t            next,
  input  logic             seen_in,
  input  hit_t             chain_in,
  output slot_t            cur,
  output logic             gt,
  output logic             seen_out,
  output hit_t             chain_out
);

  slot_t slot;
  logic  occ;
  logic  at_count;
  logic  match;
  logic  hit;

  assign cur      = slot;
  assign occ      = CNT_W'(idx) < op.count;
  assign at_count = CNT_W'(idx) == op.count;
  assign gt       = occ && (slot.layer > op.layer);
  assign match    = occ && (slot.handle == op.handle);
  assign seen_out = seen_in | match;

  always_comb begin
    unique case (op.cmd)
      CMD_INSERT:             hit = !prev_gt && (gt || at_count);
      CMD_DELETE, CMD_LOOKUP: hit = match && !seen_in;
      CMD_READ:               hit = occ && (CMP_W'(idx) == CMP_W'(op.pos));
      default:                hit = 1'b0;
    endcase
  end

  always_comb begin
    chain_out = chain_in;
    if (hit) begin
      chain_out.found  = 1'b1;
      chain_out.idx    = idx;
      if (op.cmd == CMD_INSERT) begin
        chain_out.handle = op.handle;
        chain_out.layer  = op.layer;
      end else begin
        chain_out.handle = slot.handle;
        chain_out.layer  = slot.layer;
      end
    end
  end

  // Insert shifts up from the first larger layer; delete shifts down
  // from the first match.
  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      if (op.cmd == CMD_INSERT) begin
        if (prev_gt) begin
          slot <= prev;
        end else if (hit) begin
          slot.handle <= op.handle;
          slot.layer  <= op.layer;
        end
      end else if (op.cmd == CMD_DELETE) begin
        if (seen_out) begin
          slot <= next;
        end
      end
    end
  end

endmodule

### sv/layer_sorted_handle_list.sv
// ----------------------------------------------------------------------------
// layer_sorted_handle_list
// Sorted list of handle/layer pairs built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command item (insert, delete, lookup, read) with its
//   handle, layer and position fields; rsp returns exactly one result item
//   per command with status, pair, slot index and the entry count after it.
//   An item is moved when valid and ready are both high.
//   The command is registered on acceptance, then evaluated by all cells
//   at once in the cycle that writes the result register, once that
//   register is free. A new command is accepted only after the held one
//   has been evaluated and written into the result register.
//   Stall: the result register holds while rsp.ready is low; one further
//   command may be accepted meanwhile and waits evaluated-but-uncommitted
//   until the result register frees.
//   Reset (rst, synchronous): entry count goes to zero, no item in flight,
//   no result valid. Slot contents are not cleared; slots at or above the
//   count are never read.
// ----------------------------------------------------------------------------
module layer_sorted_handle_list
  import lshl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  lshl_req_if.sink   req,
  lshl_rsp_if.source rsp
);

  // Held command
  logic                          busy;
  cmd_t                          cmd;
  logic [HANDLE_BITS-1:0]        handle;
  logic signed [LAYER_BITS-1:0]  layer;
  logic [POS_W-1:0]              pos;
  logic [CNT_W-1:0]              count;

  // Result register
  logic                          rsp_valid;
  status_t                       rsp_status;
  logic [FHND_W-1:0]             rsp_handle;
  logic signed [FLAY_W-1:0]      rsp_layer;
  logic [FIDX_W-1:0]             rsp_index;
  logic [FCNT_W-1:0]             rsp_count;

  // Chain wiring
  op_t   op;
  slot_t cur   [DEPTH];
  logic  gt    [DEPTH];
  logic  seen  [DEPTH+1];
  hit_t  chain [DEPTH+1];

  logic    out_free;
  logic    finish;
  logic    full;
  logic    found;
  status_t status_next;
  logic [CNT_W-1:0] count_next;

  assign req.ready = !busy;
  assign out_free  = !rsp_valid || rsp.ready;
  assign finish    = busy && out_free;
  assign full      = count == CNT_W'(DEPTH);
  assign found     = seen[DEPTH];

  assign op.cmd    = cmd;
  assign op.handle = handle;
  assign op.layer  = layer;
  assign op.pos    = pos;
  assign op.count  = count;
  assign op.wr_en  = finish && (((cmd == CMD_INSERT) && !full) ||
                                ((cmd == CMD_DELETE) && found));

  assign seen[0]  = 1'b0;
  assign chain[0] = '0;

  // Cell row: cell i sees its lower neighbor for insert shifts and its
  // upper neighbor for delete shifts; match and hit ripple upward.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t prev_s;
    logic  prev_g;
    slot_t next_s;

    if (i == 0) begin : g_first
      assign prev_s = cur[0];
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_s = cur[i-1];
      assign prev_g = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_s = cur[i];
    end else begin : g_inner
      assign next_s = cur[i+1];
    end

    lshl_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .op        (op),
      .prev      (prev_s),
      .prev_gt   (prev_g),
      .next      (next_s),
      .seen_in   (seen[i]),
      .chain_in  (chain[i]),
      .cur       (cur[i]),
      .gt        (gt[i]),
      .seen_out  (seen[i+1]),
      .chain_out (chain[i+1])
    );
  end

  // Status and count after the command
  always_comb begin
    count_next = count;
    unique case (cmd)
      CMD_INSERT: begin
        status_next = full ? ST_FULL : ST_OK;
        if (!full) count_next = count + CNT_W'(1);
      end
      CMD_DELETE: begin
        status_next = found ? ST_OK : ST_MISSING;
        if (found) count_next = count - CNT_W'(1);
      end
      CMD_LOOKUP: status_next = found ? ST_OK : ST_MISSING;
      CMD_READ:   status_next = chain[DEPTH].found ? ST_OK : ST_RANGE;
      default:    status_next = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        busy   <= 1'b1;
        cmd    <= cmd_t'(req.cmd);
        handle <= HANDLE_BITS'(req.handle);
        layer  <= LAYER_BITS'(req.layer);
        pos    <= req.position;
      end else if (finish) begin
        busy <= 1'b0;
      end

      if (finish) begin
        count      <= count_next;
        rsp_valid  <= 1'b1;
        rsp_status <= status_next;
        rsp_count  <= FCNT_W'(count_next);
        // Failed commands report a zero pair and index
        if (status_next == ST_OK) begin
          rsp_handle <= FHND_W'(chain[DEPTH].handle);
          rsp_layer  <= FLAY_W'(chain[DEPTH].layer);
          rsp_index  <= FIDX_W'(chain[DEPTH].idx);
        end else begin
          rsp_handle <= '0;
          rsp_layer  <= '0;
          rsp_index  <= '0;
        end
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.handle_out = rsp_handle;
  assign rsp.layer_out  = rsp_layer;
  assign rsp.index_out  = rsp_index;
  assign rsp.count      = rsp_count;

endmodule

### sv/lshl_checker.sv
// ----------------------------------------------------------------------------
// lshl_checker
// Port-level checks on the result channel of the handle list.
// ----------------------------------------------------------------------------
module lshl_checker
  import lshl_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic [STAT_W-1:0]        status,
  input logic [FHND_W-1:0]        handle_out,
  input logic signed [FLAY_W-1:0] layer_out,
  input logic [FIDX_W-1:0]        index_out,
  input logic [FCNT_W-1:0]        count
);

  // Stalled result stays valid with status and count unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(count))
    else $error("stalled result changed");

  // Nothing valid right after reset
  a_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Full only reported with a full table
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> count == FCNT_W'(DEPTH))
    else $error("full status with free slots");

  // Failures carry a zero pair and index
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |->
      (handle_out == '0) && (layer_out == '0) && (index_out == '0))
    else $error("failed command returned data");

  // Successful results carry an index no greater than the reported count
  a_idx: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_OK) |-> FCNT_W'(index_out) <= count)
    else $error("index beyond count");

endmodule

bind layer_sorted_handle_list lshl_checker u_lshl_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .handle_out (rsp.handle_out),
  .layer_out  (rsp.layer_out),
  .index_out  (rsp.index_out),
  .count      (rsp.count)
);

### dv/layer_sorted_handle_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_sorted_handle_list_tb
// Self-checking bench for the layer-sorted handle list. A driver pops
// command items from a backlog and a monitor checks every result item
// against a scoreboard model of the sorted list. The run covers directed
// corners (empty, full, ties, duplicate handles, layer extremes) and then
// about 2000 random commands under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module layer_sorted_handle_list_tb;
  import lshl_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES   = 8;     // quiet cycles after the last result
  localparam int RANDOM_ITEMS   = 2000;
  localparam int PHASE_ITEMS    = 250;
  localparam int TREND_ITEMS    = 40;    // items between grow and shrink bias flips

  // Idle pattern applied to both channels while an item is in the driver
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // Bias of the random command mix, to push the list toward full or empty
  typedef enum bit {
    TREND_GROW,
    TREND_SHRINK
  } list_trend_t;

  typedef struct {
    cmd_t                     cmd;
    logic [FHND_W-1:0]        handle;
    logic signed [FLAY_W-1:0] layer;
    logic [POS_W-1:0]         pos;
    idle_mode_t               mode;
    bit                       hold;   // wait until all results are back first
  } cmd_item_t;

  typedef struct {
    status_t                  status;
    logic [FHND_W-1:0]        handle;
    logic signed [FLAY_W-1:0] layer;
    logic [FIDX_W-1:0]        index;
    logic [FCNT_W-1:0]        count;
  } list_result_t;

  logic clk;
  logic rst;

  lshl_req_if req ();
  lshl_rsp_if rsp ();

  layer_sorted_handle_list i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // --------------------------------------------------------------------------
  // Scoreboard copy of the list. Slots below list_count are always valid;
  // the rest are never looked at.
  // --------------------------------------------------------------------------
  logic [FHND_W-1:0]        list_handle [DEPTH];
  logic signed [FLAY_W-1:0] list_layer  [DEPTH];
  int                       list_count;

  cmd_item_t    cmd_backlog[$];      // commands not yet offered to the block
  list_result_t pending_results[$];  // one per accepted command, oldest first

  idle_mode_t cur_mode;
  bit         req_fire;
  bit         rsp_fire;
  int         quiet_cycles;
  int         errors;

  // Applies one command to the scoreboard list and returns the result item
  // the block must produce for it.
  function automatic list_result_t apply_list_cmd(cmd_item_t it);
    list_result_t r;
    int           i;
    int           hit;
    r = '{ST_OK, '0, '0, '0, '0};
    case (it.cmd)
      CMD_INSERT: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new pair lands after every pair with an equal or lower layer
          i = list_count;
          while (i > 0 && list_layer[i-1] > it.layer) begin
            list_handle[i] = list_handle[i-1];
            list_layer[i]  = list_layer[i-1];
            i--;
          end
          list_handle[i] = it.handle;
          list_layer[i]  = it.layer;
          list_count++;
          r.handle = it.handle;
          r.layer  = it.layer;
          r.index  = FIDX_W'(i);
        end
      end
      CMD_DELETE, CMD_LOOKUP: begin
        hit = -1;
        for (i = 0; i < list_count; i++) begin
          if (hit < 0 && list_handle[i] == it.handle) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.handle = list_handle[hit];
          r.layer  = list_layer[hit];
          r.index  = FIDX_W'(hit);
          if (it.cmd == CMD_DELETE) begin
            for (i = hit; i + 1 < list_count; i++) begin
              list_handle[i] = list_handle[i+1];
              list_layer[i]  = list_layer[i+1];
            end
            list_count--;
          end
        end
      end
      default: begin  // read at position
        if (it.pos >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          r.handle = list_handle[it.pos];
          r.layer  = list_layer[it.pos];
          r.index  = it.pos;
        end
      end
    endcase
    r.count = FCNT_W'(list_count);
    return r;
  endfunction

  // True when the given side should sit out this cycle under the mode
  function automatic bit skip_cycle(idle_mode_t m, bit sender_side);
    case (m)
      IDLE_SENDER:   return sender_side && $urandom_range(99) < 56;
      IDLE_RECEIVER: return !sender_side && $urandom_range(99) < 56;
      IDLE_BOTH:     return $urandom_range(99) < 28;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic void queue_cmd(cmd_t c, logic [FHND_W-1:0] h,
                                    logic signed [FLAY_W-1:0] l, logic [POS_W-1:0] p,
                                    idle_mode_t m = IDLE_NONE, bit hold = 1'b0);
    cmd_item_t it;
    it = '{c, h, l, p, m, hold};
    cmd_backlog.push_back(it);
  endfunction

  function automatic cmd_t pick_cmd(list_trend_t t);
    int r;
    r = $urandom_range(99);
    if (t == TREND_GROW) begin
      if (r < 50) return CMD_INSERT;
      if (r < 65) return CMD_DELETE;
      if (r < 80) return CMD_LOOKUP;
      return CMD_READ;
    end
    if (r < 15) return CMD_INSERT;
    if (r < 60) return CMD_DELETE;
    if (r < 80) return CMD_LOOKUP;
    return CMD_READ;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, and known values on every input from time zero
  // --------------------------------------------------------------------------
  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.cmd      = CMD_READ;
    req.handle   = '0;
    req.layer    = '0;
    req.position = '0;
    rsp.ready    = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: works on the falling edge. A presented item is held until the
  // rising edge that accepts it; only then is the next one considered.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    cmd_item_t nxt;
    bit        present;
    present = 1'b0;
    if (rst) begin
      req.valid <= 1'b0;
      rsp.ready <= 1'b0;
    end else begin
      if (!req.valid || req_fire) begin
        if (cmd_backlog.size() != 0) begin
          nxt      = cmd_backlog[0];
          cur_mode = nxt.mode;
          // a hold item waits for the list to go quiet before it goes out
          if (!(nxt.hold && pending_results.size() != 0) && !skip_cycle(cur_mode, 1'b1)) begin
            present = 1'b1;
            void'(cmd_backlog.pop_front());
            req.cmd      <= nxt.cmd;
            req.handle   <= nxt.handle;
            req.layer    <= nxt.layer;
            req.position <= nxt.pos;
          end
        end
        req.valid <= present;
      end
      rsp.ready <= !skip_cycle(cur_mode, 1'b0);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. Results are checked
  // before the command accepted at the same edge is predicted; a result is
  // registered after its command, so they can never belong to each other.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_result_t want;
    cmd_item_t    seen;
    req_fire = 1'b0;
    rsp_fire = 1'b0;
    if (!rst) begin
      rsp_fire = rsp.valid && rsp.ready;
      if (rsp_fire) begin
        if (pending_results.size() == 0) begin
          $error("result item with no command outstanding: status %0d handle %0h",
                 rsp.status, rsp.handle_out);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.handle_out !== want.handle) begin
            $error("handle_out: expected %0h, got %0h", want.handle, rsp.handle_out);
            errors++;
          end
          if (rsp.layer_out !== want.layer) begin
            $error("layer_out: expected %0d, got %0d", want.layer, rsp.layer_out);
            errors++;
          end
          if (rsp.index_out !== want.index) begin
            $error("index_out: expected %0d, got %0d", want.index, rsp.index_out);
            errors++;
          end
          if (rsp.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp.count);
            errors++;
          end
        end
      end

      req_fire = req.valid && req.ready;
      if (req_fire) begin
        seen = '{cmd_t'(req.cmd), req.handle, req.layer, req.position, cur_mode, 1'b0};
        pending_results.push_back(apply_list_cmd(seen));
      end

      // watchdog: no item moved on either side for too long
      if (req_fire || rsp_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    list_trend_t              trend;
    idle_mode_t               mode;
    cmd_t                     c;
    logic [FHND_W-1:0]        h;
    logic signed [FLAY_W-1:0] l;
    int                       k;

    list_count   = 0;
    cur_mode     = IDLE_NONE;
    quiet_cycles = 0;
    errors       = 0;

    // Directed corners, no idling.
    // empty list: read, delete and lookup all miss
    queue_cmd(CMD_READ,   16'h0000, 16'sd0, 4'd0);
    queue_cmd(CMD_DELETE, 16'h0000, 16'sd0, 4'd15);
    queue_cmd(CMD_LOOKUP, 16'hFFFF, 16'sd0, 4'd0);
    // layer extremes, then a tie at zero (second goes after the first)
    queue_cmd(CMD_INSERT, 16'hFFFF, 16'sh7FFF, 4'd0);
    queue_cmd(CMD_INSERT, 16'h0000, 16'sh8000, 4'd0);
    queue_cmd(CMD_INSERT, 16'h0005, 16'sd0,    4'd0);
    queue_cmd(CMD_INSERT, 16'h0006, 16'sd0,    4'd0);
    // same handle twice: lookup and delete must hit the lower slot
    queue_cmd(CMD_INSERT, 16'h0005, -16'sd1,   4'd0);
    queue_cmd(CMD_LOOKUP, 16'h0005, 16'sd0,    4'd0);
    queue_cmd(CMD_DELETE, 16'h0005, 16'sd0,    4'd0);
    queue_cmd(CMD_LOOKUP, 16'h0005, 16'sd0,    4'd0);
    // read the top slot, then the first position past it
    queue_cmd(CMD_READ,   16'h0000, 16'sd0,    4'd3);
    queue_cmd(CMD_READ,   16'h0000, 16'sd0,    4'd4);
    // fill to DEPTH with spread layers
    for (k = 0; k < DEPTH - 4; k++) begin
      queue_cmd(CMD_INSERT, FHND_W'(16'hA5A0 + k), FLAY_W'(k * 4001 - 24000), 4'd0);
    end
    // full: insert refused, last slot readable, top pair removable
    queue_cmd(CMD_INSERT, 16'h1234, 16'sd0, 4'd0);
    queue_cmd(CMD_READ,   16'h0000, 16'sd0, 4'd15);
    queue_cmd(CMD_DELETE, 16'hFFFF, 16'sd0, 4'd0);

    // Random part: phases of fixed idle mode, each opening with a hold
    // item so the sender pauses until everything before it has returned.
    // Within a phase the mix flips between growing and shrinking so the
    // list keeps sweeping between empty and full.
    trend = TREND_GROW;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      mode = idle_mode_t'((k / PHASE_ITEMS) % 4);
      if (k % TREND_ITEMS == 0) trend = list_trend_t'(~trend);
      c = pick_cmd(trend);
      // small handle pool so deletes and lookups mostly hit
      h = ($urandom_range(99) < 85) ? FHND_W'($urandom_range(15)) : FHND_W'($urandom);
      // small layers give many ties, full range covers every bit
      l = ($urandom_range(99) < 60) ? FLAY_W'($urandom_range(6) - 3) : FLAY_W'($urandom);
      queue_cmd(c, h, l, POS_W'($urandom_range(15)), mode, k % PHASE_ITEMS == 0);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || req.valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
